/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the rational accumulator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked property, ignored while reset is asserted
`define RAG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// clocked property, also checked during reset
`define RAG_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RAG_ASSERT(lbl, clk, rstn, prop, msg)
`define RAG_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

/* rtl/core/rag_pkg.sv */
// ----------------------------------------------------------------------------
// rag_pkg
// Types and constants shared by the microcode sequencer and the datapath.
// ----------------------------------------------------------------------------
package rag_pkg;

    localparam int STEP_BITS = 6;

    // operation requested by an input beat
    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_SUB  = 2'd2,
        MODE_MUL  = 2'd3
    } t_mode;

    // datapath registers addressed by the microcode
    typedef enum logic [3:0] {
        REG_X  = 4'd0,
        REG_Y  = 4'd1,
        REG_A  = 4'd2,
        REG_B  = 4'd3,
        REG_T  = 4'd4,
        REG_N  = 4'd5,
        REG_D  = 4'd6,
        REG_ON = 4'd7,
        REG_OD = 4'd8
    } t_reg;

    // write-back source
    typedef enum logic [1:0] {
        SRC_X      = 2'd0,
        SRC_LO     = 2'd1,
        SRC_REM    = 2'd2,
        SRC_ADDSUB = 2'd3
    } t_src;

    // iterative unit operation
    typedef enum logic [1:0] {
        UOP_NONE = 2'd0,
        UOP_MUL  = 2'd1,
        UOP_DIV  = 2'd2
    } t_uop;

    // sequencer branch condition
    typedef enum logic [3:0] {
        COND_NEXT     = 4'd0,
        COND_ALWAYS   = 4'd1,
        COND_NO_IN    = 4'd2,
        COND_BUSY     = 4'd3,
        COND_BZERO    = 4'd4,
        COND_GZERO    = 4'd5,
        COND_LOAD     = 4'd6,
        COND_MUL      = 4'd7,
        COND_OUT_WAIT = 4'd8,
        COND_CALL     = 4'd9,
        COND_RET      = 4'd10
    } t_cond;

    // one microcode word
    typedef struct packed {
        logic                 take_in;
        t_uop                 uop;
        t_reg                 sel_x;
        t_reg                 sel_y;
        logic                 we;
        t_reg                 dst;
        t_src                 src;
        logic                 out_load;
        t_cond                cond;
        logic [STEP_BITS-1:0] target;
    } t_uword;

    // datapath status fed back to the sequencer
    typedef struct packed {
        logic  in_accept;
        logic  busy;
        logic  b_zero;
        logic  g_zero;
        t_mode mode;
        logic  out_wait;
    } t_seq_stat;

endpackage

/* rtl/core/rag_mdu.sv */
// ----------------------------------------------------------------------------
// rag_mdu
// Bit-serial multiply (low word) and truncating signed divide/remainder.
// ----------------------------------------------------------------------------
module rag_mdu #(
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  rag_pkg::t_uop        i_op,
    input  logic [WORD_BITS-1:0] i_x,
    input  logic [WORD_BITS-1:0] i_y,
    output logic                 o_busy,
    output logic [WORD_BITS-1:0] o_lo,
    output logic [WORD_BITS-1:0] o_rem
);

    localparam int CNT_BITS = $clog2(WORD_BITS);

    logic                 r_busy;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_is_mul;
    logic                 r_qneg;
    logic                 r_rneg;
    logic [WORD_BITS-1:0] r_q;
    logic [WORD_BITS:0]   r_r;
    logic [WORD_BITS-1:0] r_b;

    logic [WORD_BITS:0]   div_sh;
    logic [WORD_BITS:0]   div_diff;
    logic                 div_ge;
    logic [WORD_BITS-1:0] mul_sum;
    logic [WORD_BITS-1:0] x_mag;
    logic [WORD_BITS-1:0] y_mag;

    // magnitudes of the operands for the divide
    assign x_mag = i_x[WORD_BITS-1] ? (~i_x + 1'b1) : i_x;
    assign y_mag = i_y[WORD_BITS-1] ? (~i_y + 1'b1) : i_y;

    // one restoring-division step
    assign div_sh   = {r_r[WORD_BITS-1:0], r_q[WORD_BITS-1]};
    assign div_diff = div_sh - {1'b0, r_b};
    assign div_ge   = (div_sh >= {1'b0, r_b});

    // one shift-add step
    assign mul_sum = r_r[WORD_BITS-1:0] + (r_q[0] ? r_b : '0);

    // control: count one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_BITS'(WORD_BITS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // operand and partial-result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_is_mul <= (i_op == rag_pkg::UOP_MUL);
            r_r      <= '0;
            if (i_op == rag_pkg::UOP_MUL) begin
                r_q   <= i_y;
                r_b   <= i_x;
                r_qneg <= 1'b0;
                r_rneg <= 1'b0;
            end else begin
                r_q   <= x_mag;
                r_b   <= y_mag;
                r_qneg <= i_x[WORD_BITS-1] ^ i_y[WORD_BITS-1];
                r_rneg <= i_x[WORD_BITS-1];
            end
        end else if (r_busy) begin
            if (r_is_mul) begin
                r_r <= {1'b0, mul_sum};
                r_b <= {r_b[WORD_BITS-2:0], 1'b0};
                r_q <= {1'b0, r_q[WORD_BITS-1:1]};
            end else begin
                r_r <= div_ge ? div_diff : div_sh;
                r_q <= {r_q[WORD_BITS-2:0], div_ge};
            end
        end
    end

    // sign fix-up of held results
    assign o_busy = r_busy;
    assign o_lo   = r_is_mul ? r_r[WORD_BITS-1:0] : (r_qneg ? (~r_q + 1'b1) : r_q);
    assign o_rem  = r_rneg ? (~r_r[WORD_BITS-1:0] + 1'b1) : r_r[WORD_BITS-1:0];

endmodule

/* rtl/core/rag_seq.sv */
// ----------------------------------------------------------------------------
// rag_seq
// Microcode ROM, step counter and branch logic with a one-level return.
// ----------------------------------------------------------------------------
module rag_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rag_pkg::t_seq_stat  i_stat,
    output rag_pkg::t_uword     o_uword
);

    localparam int SB = rag_pkg::STEP_BITS;

    // program entry points
    localparam logic [SB-1:0] S_IDLE   = SB'(0);
    localparam logic [SB-1:0] S_WT1    = SB'(6);
    localparam logic [SB-1:0] S_WT2    = SB'(8);
    localparam logic [SB-1:0] S_WT3    = SB'(10);
    localparam logic [SB-1:0] S_LOAD   = SB'(12);
    localparam logic [SB-1:0] S_MUL    = SB'(14);
    localparam logic [SB-1:0] S_WT4    = SB'(15);
    localparam logic [SB-1:0] S_WT5    = SB'(17);
    localparam logic [SB-1:0] S_ACC    = SB'(18);
    localparam logic [SB-1:0] S_OUT    = SB'(21);
    localparam logic [SB-1:0] S_RED    = SB'(23);
    localparam logic [SB-1:0] S_LOOP   = SB'(25);
    localparam logic [SB-1:0] S_WT6    = SB'(27);
    localparam logic [SB-1:0] S_GDONE  = SB'(30);
    localparam logic [SB-1:0] S_WT7    = SB'(32);
    localparam logic [SB-1:0] S_WT8    = SB'(34);
    localparam logic [SB-1:0] S_RET    = SB'(35);

    logic [SB-1:0]   r_step;
    logic [SB-1:0]   n_step;
    logic [SB-1:0]   r_ret;
    logic [SB-1:0]   n_ret;
    logic            taken;
    rag_pkg::t_uword uw;

    // control store
    function automatic rag_pkg::t_uword ucode(input logic [SB-1:0] s);
        rag_pkg::t_uword w;
        w = '0;
        case (s)
            6'd0: begin
                w.take_in = 1'b1;
                w.cond = rag_pkg::COND_NO_IN; w.target = S_IDLE;
            end
            6'd1: begin w.cond = rag_pkg::COND_CALL; w.target = S_RED; end
            6'd2: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_ON;
                w.src = rag_pkg::SRC_X; w.sel_x = rag_pkg::REG_X;
            end
            6'd3: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_OD;
                w.src = rag_pkg::SRC_X; w.sel_x = rag_pkg::REG_Y;
                w.cond = rag_pkg::COND_LOAD; w.target = S_LOAD;
            end
            6'd4: begin w.cond = rag_pkg::COND_MUL; w.target = S_MUL; end
            // add / subtract: T = N*OD, X = ON*D, Y = D*OD, X = T +/- X
            6'd5: begin
                w.uop = rag_pkg::UOP_MUL;
                w.sel_x = rag_pkg::REG_N; w.sel_y = rag_pkg::REG_OD;
            end
            6'd6: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_T; w.src = rag_pkg::SRC_LO;
                w.cond = rag_pkg::COND_BUSY; w.target = S_WT1;
            end
            6'd7: begin
                w.uop = rag_pkg::UOP_MUL;
                w.sel_x = rag_pkg::REG_ON; w.sel_y = rag_pkg::REG_D;
            end
            6'd8: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_X; w.src = rag_pkg::SRC_LO;
                w.cond = rag_pkg::COND_BUSY; w.target = S_WT2;
            end
            6'd9: begin
                w.uop = rag_pkg::UOP_MUL;
                w.sel_x = rag_pkg::REG_D; w.sel_y = rag_pkg::REG_OD;
            end
            6'd10: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_Y; w.src = rag_pkg::SRC_LO;
                w.cond = rag_pkg::COND_BUSY; w.target = S_WT3;
            end
            6'd11: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_X; w.src = rag_pkg::SRC_ADDSUB;
                w.cond = rag_pkg::COND_ALWAYS; w.target = S_ACC;
            end
            // load: X = ON, Y = OD
            6'd12: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_X;
                w.src = rag_pkg::SRC_X; w.sel_x = rag_pkg::REG_ON;
            end
            6'd13: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_Y;
                w.src = rag_pkg::SRC_X; w.sel_x = rag_pkg::REG_OD;
                w.cond = rag_pkg::COND_ALWAYS; w.target = S_ACC;
            end
            // multiply: X = N*ON, Y = D*OD, then fall into the commit
            6'd14: begin
                w.uop = rag_pkg::UOP_MUL;
                w.sel_x = rag_pkg::REG_N; w.sel_y = rag_pkg::REG_ON;
            end
            6'd15: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_X; w.src = rag_pkg::SRC_LO;
                w.cond = rag_pkg::COND_BUSY; w.target = S_WT4;
            end
            6'd16: begin
                w.uop = rag_pkg::UOP_MUL;
                w.sel_x = rag_pkg::REG_D; w.sel_y = rag_pkg::REG_OD;
            end
            6'd17: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_Y; w.src = rag_pkg::SRC_LO;
                w.cond = rag_pkg::COND_BUSY; w.target = S_WT5;
            end
            // reduce the new accumulator and commit it
            6'd18: begin w.cond = rag_pkg::COND_CALL; w.target = S_RED; end
            6'd19: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_N;
                w.src = rag_pkg::SRC_X; w.sel_x = rag_pkg::REG_X;
            end
            6'd20: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_D;
                w.src = rag_pkg::SRC_X; w.sel_x = rag_pkg::REG_Y;
            end
            6'd21: begin
                w.out_load = 1'b1;
                w.cond = rag_pkg::COND_OUT_WAIT; w.target = S_OUT;
            end
            6'd22: begin w.cond = rag_pkg::COND_ALWAYS; w.target = S_IDLE; end
            // subroutine: reduce X/Y by Euclid's gcd
            6'd23: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_A;
                w.src = rag_pkg::SRC_X; w.sel_x = rag_pkg::REG_X;
            end
            6'd24: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_B;
                w.src = rag_pkg::SRC_X; w.sel_x = rag_pkg::REG_Y;
            end
            6'd25: begin w.cond = rag_pkg::COND_BZERO; w.target = S_GDONE; end
            6'd26: begin
                w.uop = rag_pkg::UOP_DIV;
                w.sel_x = rag_pkg::REG_A; w.sel_y = rag_pkg::REG_B;
            end
            6'd27: begin w.cond = rag_pkg::COND_BUSY; w.target = S_WT6; end
            6'd28: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_A;
                w.src = rag_pkg::SRC_X; w.sel_x = rag_pkg::REG_B;
            end
            6'd29: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_B; w.src = rag_pkg::SRC_REM;
                w.cond = rag_pkg::COND_ALWAYS; w.target = S_LOOP;
            end
            6'd30: begin w.cond = rag_pkg::COND_GZERO; w.target = S_RET; end
            6'd31: begin
                w.uop = rag_pkg::UOP_DIV;
                w.sel_x = rag_pkg::REG_X; w.sel_y = rag_pkg::REG_A;
            end
            6'd32: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_X; w.src = rag_pkg::SRC_LO;
                w.cond = rag_pkg::COND_BUSY; w.target = S_WT7;
            end
            6'd33: begin
                w.uop = rag_pkg::UOP_DIV;
                w.sel_x = rag_pkg::REG_Y; w.sel_y = rag_pkg::REG_A;
            end
            6'd34: begin
                w.we = 1'b1; w.dst = rag_pkg::REG_Y; w.src = rag_pkg::SRC_LO;
                w.cond = rag_pkg::COND_BUSY; w.target = S_WT8;
            end
            6'd35: begin w.cond = rag_pkg::COND_RET; end
            default: begin w.cond = rag_pkg::COND_ALWAYS; w.target = S_IDLE; end
        endcase
        return w;
    endfunction

    assign uw      = ucode(r_step);
    assign o_uword = uw;

    // branch condition
    always_comb begin
        case (uw.cond)
            rag_pkg::COND_ALWAYS:   taken = 1'b1;
            rag_pkg::COND_NO_IN:    taken = !i_stat.in_accept;
            rag_pkg::COND_BUSY:     taken = i_stat.busy;
            rag_pkg::COND_BZERO:    taken = i_stat.b_zero;
            rag_pkg::COND_GZERO:    taken = i_stat.g_zero;
            rag_pkg::COND_LOAD:     taken = (i_stat.mode == rag_pkg::MODE_LOAD);
            rag_pkg::COND_MUL:      taken = (i_stat.mode == rag_pkg::MODE_MUL);
            rag_pkg::COND_OUT_WAIT: taken = i_stat.out_wait;
            rag_pkg::COND_CALL:     taken = 1'b1;
            default:                taken = 1'b0;
        endcase
    end

    // next step and return address
    always_comb begin
        n_ret = r_ret;
        if (uw.cond == rag_pkg::COND_RET) begin
            n_step = r_ret;
        end else if (taken) begin
            n_step = uw.target;
        end else begin
            n_step = r_step + 1'b1;
        end
        if (uw.cond == rag_pkg::COND_CALL) begin
            n_ret = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
            r_ret  <= S_IDLE;
        end else begin
            r_step <= n_step;
            r_ret  <= n_ret;
        end
    end

endmodule

/* rtl/core/rational_accumulator_gcd.sv */
// ----------------------------------------------------------------------------
// rational_accumulator_gcd
// Running fraction with load/add/subtract/multiply and gcd reduction.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: i_mode, i_operand_num, i_operand_den, taken when i_valid is
//   high and o_stall is low. Output beat: o_result_num, o_result_den, taken
//   when o_valid is high and i_stall is low. Each input beat gives exactly
//   one output beat, the reduced accumulator after the operation.
//   One item is worked at a time. A microcode sequencer drives one shared
//   bit-serial multiply/divide unit. Each beat runs three multiplies for
//   add/subtract, two for multiply and none for load, and two Euclid gcd
//   reductions, one of the operand and one of the new accumulator; a zero
//   gcd skips the two final divides. After the result is loaded the
//   sequencer returns to its idle step, where the next beat is taken.
//   The result sits in an output register, so the next beat is taken while
//   a result waits; if the receiver stalls, the following result waits in
//   the sequencer until the register frees.
//   Reset (synchronous, active low) sets the fraction to 0/1, holds o_stall
//   high and drops o_valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rational_accumulator_gcd #(
    parameter int WORD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_operand_num,
    input  logic signed [31:0] i_operand_den,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_num,
    output logic signed [31:0] o_result_den
);

    rag_pkg::t_uword    uw;
    rag_pkg::t_seq_stat stat;

    logic                 in_accept;
    logic                 out_wait;
    logic                 out_load;
    logic                 wr_en;
    logic                 mdu_busy;
    logic [WORD_BITS-1:0] mdu_lo;
    logic [WORD_BITS-1:0] mdu_rem;
    logic [WORD_BITS-1:0] opnd_x;
    logic [WORD_BITS-1:0] opnd_y;
    logic [WORD_BITS-1:0] wval;
    logic [WORD_BITS-1:0] ext_num;
    logic [WORD_BITS-1:0] ext_den;

    rag_pkg::t_mode       r_mode;
    logic [WORD_BITS-1:0] r_x;
    logic [WORD_BITS-1:0] r_y;
    logic [WORD_BITS-1:0] r_a;
    logic [WORD_BITS-1:0] r_b;
    logic [WORD_BITS-1:0] r_t;
    logic [WORD_BITS-1:0] r_n;
    logic [WORD_BITS-1:0] r_d;
    logic [WORD_BITS-1:0] r_on;
    logic [WORD_BITS-1:0] r_od;
    logic                 r_out_valid;
    logic [31:0]          r_out_num;
    logic [31:0]          r_out_den;

    // sequencer and shared arithmetic unit
    rag_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uword (uw)
    );

    rag_mdu #(
        .WORD_BITS (WORD_BITS)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (uw.uop != rag_pkg::UOP_NONE),
        .i_op    (uw.uop),
        .i_x     (opnd_x),
        .i_y     (opnd_y),
        .o_busy  (mdu_busy),
        .o_lo    (mdu_lo),
        .o_rem   (mdu_rem)
    );

    // handshakes; no beat is taken while reset is held
    assign o_stall   = !uw.take_in || !i_rst_n;
    assign in_accept = i_valid && !o_stall;
    assign out_wait  = r_out_valid && i_stall;
    assign out_load  = uw.out_load && !out_wait;

    assign stat.in_accept = in_accept;
    assign stat.busy      = mdu_busy;
    assign stat.b_zero    = (r_b == '0);
    assign stat.g_zero    = (r_a == '0);
    assign stat.mode      = r_mode;
    assign stat.out_wait  = out_wait;

    // operand fields widened to the word; zero denominator taken as one
    assign ext_num = WORD_BITS'(i_operand_num);
    assign ext_den = WORD_BITS'(i_operand_den);

    // operand muxes
    always_comb begin
        case (uw.sel_x)
            rag_pkg::REG_X:  opnd_x = r_x;
            rag_pkg::REG_Y:  opnd_x = r_y;
            rag_pkg::REG_A:  opnd_x = r_a;
            rag_pkg::REG_B:  opnd_x = r_b;
            rag_pkg::REG_T:  opnd_x = r_t;
            rag_pkg::REG_N:  opnd_x = r_n;
            rag_pkg::REG_D:  opnd_x = r_d;
            rag_pkg::REG_ON: opnd_x = r_on;
            rag_pkg::REG_OD: opnd_x = r_od;
            default:         opnd_x = r_x;
        endcase
    end

    always_comb begin
        case (uw.sel_y)
            rag_pkg::REG_X:  opnd_y = r_x;
            rag_pkg::REG_Y:  opnd_y = r_y;
            rag_pkg::REG_A:  opnd_y = r_a;
            rag_pkg::REG_B:  opnd_y = r_b;
            rag_pkg::REG_T:  opnd_y = r_t;
            rag_pkg::REG_N:  opnd_y = r_n;
            rag_pkg::REG_D:  opnd_y = r_d;
            rag_pkg::REG_ON: opnd_y = r_on;
            rag_pkg::REG_OD: opnd_y = r_od;
            default:         opnd_y = r_y;
        endcase
    end

    // write-back value; unit results only once the unit is idle
    always_comb begin
        case (uw.src)
            rag_pkg::SRC_X:      wval = opnd_x;
            rag_pkg::SRC_LO:     wval = mdu_lo;
            rag_pkg::SRC_REM:    wval = mdu_rem;
            rag_pkg::SRC_ADDSUB: wval = (r_mode == rag_pkg::MODE_SUB) ? (r_t - r_x)
                                                                       : (r_t + r_x);
            default:             wval = opnd_x;
        endcase
    end

    assign wr_en = uw.we && !(mdu_busy && (uw.src == rag_pkg::SRC_LO ||
                                           uw.src == rag_pkg::SRC_REM));

    // working registers; X/Y also capture the operand beat
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode <= rag_pkg::t_mode'(i_mode);
            r_x    <= ext_num;
            r_y    <= (ext_den == '0) ? WORD_BITS'(1) : ext_den;
        end else if (wr_en) begin
            if (uw.dst == rag_pkg::REG_X) r_x <= wval;
            if (uw.dst == rag_pkg::REG_Y) r_y <= wval;
        end
        if (wr_en) begin
            if (uw.dst == rag_pkg::REG_A)  r_a  <= wval;
            if (uw.dst == rag_pkg::REG_B)  r_b  <= wval;
            if (uw.dst == rag_pkg::REG_T)  r_t  <= wval;
            if (uw.dst == rag_pkg::REG_ON) r_on <= wval;
            if (uw.dst == rag_pkg::REG_OD) r_od <= wval;
        end
    end

    // accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
            r_d <= WORD_BITS'(1);
        end else if (wr_en) begin
            if (uw.dst == rag_pkg::REG_N) r_n <= wval;
            if (uw.dst == rag_pkg::REG_D) r_d <= wval;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_num <= 32'(r_n);
            r_out_den <= 32'(r_d);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_result_num = r_out_num;
    assign o_result_den = r_out_den;

    // checks
    `RAG_ASSERT(a_mdu_free, i_clk, i_rst_n, (uw.uop != rag_pkg::UOP_NONE) |-> !mdu_busy, "unit started while busy")
    `RAG_ASSERT(a_one_item, i_clk, i_rst_n, in_accept |=> o_stall, "second beat taken during work")
    `RAG_ASSERT(a_out_src, i_clk, i_rst_n, $rose(o_valid) |-> $past(uw.out_load), "result shown outside output step")
    `RAG_ASSERT(a_reset_acc, i_clk, i_rst_n, $past(!i_rst_n) |-> (r_n == '0 && r_d == WORD_BITS'(1) && !o_valid), "accumulator not reset to 0/1")

endmodule
